[design/gca_pkg.sv]
`default_nettype none

package gca_pkg;

    // Field widths of the stream payloads
    localparam int GROUP_W = 10;
    localparam int VALUE_W = 64;
    localparam int ROWS_W  = 32;
    localparam int OP_W    = 3;

    // s_tdata: group, value; padded to whole bytes
    localparam int S_FIELDS_W = GROUP_W + VALUE_W;
    localparam int S_TDATA_W  = ((S_FIELDS_W + 7) / 8) * 8;
    // m_tdata: group_out, result, row_count; padded to whole bytes
    localparam int M_FIELDS_W = GROUP_W + VALUE_W + ROWS_W;
    localparam int M_TDATA_W  = ((M_FIELDS_W + 7) / 8) * 8;

    // Configuration port
    localparam int PADDR_W = 4;
    localparam int PDATA_W = 64;

    localparam int NUM_GROUPS_DEF = 1024;

    localparam logic [ROWS_W-1:0]  ROWS_MAX       = '1;
    localparam logic [VALUE_W-1:0] NULL_VALUE_RST = {1'b1, {(VALUE_W-1){1'b0}}};

    // Operation codes
    localparam logic [OP_W-1:0] OP_FIRST = 3'd0;
    localparam logic [OP_W-1:0] OP_LAST  = 3'd1;
    localparam logic [OP_W-1:0] OP_SUM   = 3'd2;
    localparam logic [OP_W-1:0] OP_MAX   = 3'd3;
    localparam logic [OP_W-1:0] OP_MIN   = 3'd4;
    localparam logic [OP_W-1:0] OP_COUNT = 3'd5;

    // Item modes
    localparam logic MODE_ACCUM = 1'b0;
    localparam logic MODE_READ  = 1'b1;

    // One entry of the group table
    typedef struct packed {
        logic [VALUE_W-1:0] acc;
        logic               has;
        logic [ROWS_W-1:0]  rows;
    } entry_t;

    // Controller to datapath
    typedef struct packed {
        logic clr_en;    // write a cleared entry at the sweep address
        logic rd_en;     // capture the item and read its entry
        logic wr_en;     // write the updated entry back
        logic load_out;  // load the result register
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic is_read;   // captured item is a read
        logic clr_last;  // sweep is at its last entry
    } sts_t;

    // Ops 5..7 all behave as count
    function automatic logic is_count_op(input logic [OP_W-1:0] op);
        return op > OP_MIN;
    endfunction

endpackage

`default_nettype wire

[design/gca_ctrl.sv]
`default_nettype none

module gca_ctrl (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_tvalid,
    output logic               s_tready,
    output logic               m_tvalid,
    input  wire logic          m_tready,
    input  wire gca_pkg::sts_t sts,
    output gca_pkg::cmd_t      cmd
);
    import gca_pkg::*;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   m_tvalid_reg;
    logic   m_tvalid_next;
    logic   exec_go;

    // A read may finish only when the result slot is free or draining
    assign exec_go = !sts.is_read || !m_tvalid_reg || m_tready;

    always_comb begin
        cmd           = '0;
        state_next    = state_reg;
        m_tvalid_next = m_tvalid_reg;
        if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
        case (state_reg)
            ST_CLEAR: begin
                cmd.clr_en = 1'b1;
                if (sts.clr_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.rd_en  = 1'b1;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (exec_go) begin
                    cmd.wr_en    = 1'b1;
                    cmd.load_out = sts.is_read;
                    state_next   = ST_IDLE;
                    if (sts.is_read) begin
                        m_tvalid_next = 1'b1;
                    end
                end
            end
            default: begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;

endmodule

`default_nettype wire

[design/gca_datapath.sv]
`default_nettype none

module gca_datapath #(
    parameter int NUM_GROUPS = gca_pkg::NUM_GROUPS_DEF
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire gca_pkg::cmd_t                 cmd,
    output gca_pkg::sts_t                      sts,
    input  wire logic [gca_pkg::OP_W-1:0]      operation,
    input  wire logic [gca_pkg::VALUE_W-1:0]   null_value,
    input  wire logic [gca_pkg::S_TDATA_W-1:0] s_tdata,
    input  wire logic                          s_tuser,
    output logic      [gca_pkg::M_TDATA_W-1:0] m_tdata,
    output logic                               m_tuser
);
    import gca_pkg::*;

    localparam int ADDR_W = (NUM_GROUPS > 1) ? $clog2(NUM_GROUPS) : 1;

    entry_t mem [NUM_GROUPS];

    entry_t              rd_data_reg;
    logic                mode_reg;
    logic [GROUP_W-1:0]  group_reg;
    logic [VALUE_W-1:0]  value_reg;
    logic [ADDR_W-1:0]   clr_cnt_reg;
    logic [M_TDATA_W-1:0] m_tdata_reg;
    logic                m_tuser_reg;

    logic [GROUP_W-1:0]  s_group;
    logic [VALUE_W-1:0]  s_value;
    logic                in_range;
    logic                we;
    logic [ADDR_W-1:0]   wr_addr;
    entry_t              wr_data;
    entry_t              upd;
    logic [ROWS_W-1:0]   out_rows;
    logic                out_has;
    logic [VALUE_W-1:0]  out_result;
    logic                out_empty;

    assign s_group  = s_tdata[GROUP_W-1:0];
    assign s_value  = s_tdata[GROUP_W +: VALUE_W];
    assign in_range = 32'(group_reg) < NUM_GROUPS;

    // Item capture and table read
    always_ff @(posedge aclk) begin
        if (cmd.rd_en) begin
            mode_reg    <= s_tuser;
            group_reg   <= s_group;
            value_reg   <= s_value;
            rd_data_reg <= mem[ADDR_W'(s_group)];
        end
    end

    // Post-reset sweep address
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_cnt_reg <= '0;
        end else if (cmd.clr_en) begin
            clr_cnt_reg <= clr_cnt_reg + 1'b1;
        end
    end

    // Entry update
    always_comb begin
        upd = rd_data_reg;
        if (mode_reg == MODE_READ) begin
            upd.has  = 1'b0;
            upd.rows = '0;
        end else begin
            if (rd_data_reg.rows != ROWS_MAX) begin
                upd.rows = rd_data_reg.rows + 1'b1;
            end
            if (!is_count_op(operation) && value_reg != null_value) begin
                if (!rd_data_reg.has) begin
                    upd.acc = value_reg;
                    upd.has = 1'b1;
                end else begin
                    case (operation)
                        OP_FIRST: upd.acc = rd_data_reg.acc;
                        OP_LAST:  upd.acc = value_reg;
                        OP_SUM:   upd.acc = rd_data_reg.acc + value_reg;
                        OP_MAX: begin
                            if ($signed(value_reg) > $signed(rd_data_reg.acc)) begin
                                upd.acc = value_reg;
                            end
                        end
                        OP_MIN: begin
                            if ($signed(value_reg) < $signed(rd_data_reg.acc)) begin
                                upd.acc = value_reg;
                            end
                        end
                        default: upd.acc = rd_data_reg.acc;
                    endcase
                end
            end
        end
    end

    always_comb begin
        if (cmd.clr_en) begin
            we          = 1'b1;
            wr_addr     = clr_cnt_reg;
            wr_data     = '0;
        end else begin
            we          = cmd.wr_en && in_range;
            wr_addr     = ADDR_W'(group_reg);
            wr_data     = upd;
        end
    end

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Result of a read
    always_comb begin
        out_rows = in_range ? rd_data_reg.rows : '0;
        out_has  = in_range && rd_data_reg.has;
        if (is_count_op(operation)) begin
            out_result = VALUE_W'(out_rows);
            out_empty  = 1'b0;
        end else if (out_has) begin
            out_result = rd_data_reg.acc;
            out_empty  = 1'b0;
        end else begin
            out_result = null_value;
            out_empty  = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            m_tdata_reg <= M_TDATA_W'({out_rows, out_result, group_reg});
            m_tuser_reg <= out_empty;
        end
    end

    assign sts.is_read  = (mode_reg == MODE_READ);
    assign sts.clr_last = (clr_cnt_reg == ADDR_W'(NUM_GROUPS - 1));
    assign m_tdata      = m_tdata_reg;
    assign m_tuser      = m_tuser_reg;

endmodule

`default_nettype wire

[design/grouped_column_aggregator.sv]
// A read transaction's result reaches m_tvalid through ST_EXEC and the result register,
//   later only while an earlier result still waits on the result stream.
// One transaction at a time: each item does a read-modify-write of its entry in the
//   single-port group table, whose read data is registered.
// Reset (aresetn low, synchronous): clears control and configuration, then a sweep of all
//   NUM_GROUPS entries zeroes the table with s_tready low; configuration writes are taken.
`default_nettype none

module grouped_column_aggregator #(
    parameter int NUM_GROUPS = gca_pkg::NUM_GROUPS_DEF
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    // Input stream
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [gca_pkg::S_TDATA_W-1:0] s_tdata,  // group[9:0], value[73:10], zero pad
    input  wire logic                          s_tuser,  // mode: 0 accumulate, 1 read and clear
    // Result stream
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic      [gca_pkg::M_TDATA_W-1:0] m_tdata,  // group_out[9:0], result[73:10],
                                                         // row_count[105:74], zero pad
    output logic                               m_tuser,  // empty_res
    // Configuration port
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [gca_pkg::PADDR_W-1:0]   paddr,
    input  wire logic [gca_pkg::PDATA_W-1:0]   pwdata,
    output logic      [gca_pkg::PDATA_W-1:0]   prdata,
    output logic                               pready
);
    import gca_pkg::*;

    // Register map (8-byte stride, decoded on paddr[3]):
    //   0x0 operation  (bits 2:0)
    //   0x8 null_value (bits 63:0)
    logic [OP_W-1:0]    operation_reg;
    logic [VALUE_W-1:0] null_value_reg;
    logic               cfg_wr;

    cmd_t cmd;
    sts_t sts;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            operation_reg  <= OP_FIRST;
            null_value_reg <= NULL_VALUE_RST;
        end else if (cfg_wr) begin
            if (paddr[3]) begin
                null_value_reg <= pwdata;
            end else begin
                operation_reg <= pwdata[OP_W-1:0];
            end
        end
    end

    assign prdata = paddr[3] ? null_value_reg : PDATA_W'(operation_reg);

    // Sequencing: sweep, accept, update/write back, hand result to the output register
    gca_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // Group table, update logic and result register
    gca_datapath #(
        .NUM_GROUPS (NUM_GROUPS)
    ) u_datapath (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .sts        (sts),
        .operation  (operation_reg),
        .null_value (null_value_reg),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser)
    );

endmodule

`default_nettype wire

[design/gca_checker.sv]
`default_nettype none

module gca_checker (
    input wire logic                          aclk,
    input wire logic                          aresetn,
    input wire logic                          s_tvalid,
    input wire logic                          s_tready,
    input wire logic                          s_tuser,
    input wire logic                          m_tvalid,
    input wire logic                          m_tready,
    input wire logic [gca_pkg::M_TDATA_W-1:0] m_tdata,
    input wire logic                          m_tuser
);
    import gca_pkg::*;

    logic s_acc;
    assign s_acc = s_tvalid && s_tready;

    // Reset drops the result and holds off input as the sweep starts
    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid && !s_tready)
        else $error("outputs not idle after reset");

    // One item in flight: no accept in the cycle after an accept
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        s_acc |=> !s_tready)
        else $error("second transaction accepted while busy");

    // An accumulate transaction never produces a result
    a_accum_silent: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_acc && s_tuser == MODE_ACCUM && !m_tvalid) |=> ##1 !m_tvalid)
        else $error("result produced by accumulate transaction");

    // Stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

endmodule

bind grouped_column_aggregator gca_checker u_gca_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

`default_nettype wire
